// File: design/hpbm_pkg.sv
// shared types and constants of the heater burst-fire power modulator
package hpbm_pkg;

    // action codes carried in tuser of the input channel
    typedef enum logic [2:0] {
        ACT_TICK  = 3'd0,
        ACT_SET   = 3'd1,
        ACT_SHIFT = 3'd2,
        ACT_PID   = 3'd3,
        ACT_START = 3'd4,
        ACT_STOP  = 3'd5
    } action_t;

    // configuration register indexes
    localparam logic [2:0] CFG_FULL_SCALE = 3'd0;
    localparam logic [2:0] CFG_RELAY      = 3'd1;
    localparam logic [2:0] CFG_GAIN_P     = 3'd2;
    localparam logic [2:0] CFG_GAIN_I     = 3'd3;
    localparam logic [2:0] CFG_GAIN_D     = 3'd4;

    // fixed point of the pid stage: products carry 12 fraction bits
    localparam int unsigned Q_FRAC  = 12;
    localparam int unsigned LEVEL_W = 7;
    localparam int unsigned INTEG_W = Q_FRAC + LEVEL_W;
    localparam logic [INTEG_W-1:0] INTEG_TOP = INTEG_W'(100 << Q_FRAC);

    localparam logic [7:0] FULL_SCALE_RESET = 8'd100;

    // one input item as held in the input register
    typedef struct packed {
        action_t            action;
        logic               relay_on;
        logic [7:0]         power_request;
        logic signed [7:0]  power_step;
        logic signed [15:0] measured_temp;
        logic signed [15:0] target_temp;
    } in_item_t;

    // pid stage results handed back to the control logic
    typedef struct packed {
        logic [INTEG_W-1:0] integ;
        logic signed [16:0] err;
        logic [LEVEL_W-1:0] level;
    } pid_result_t;

endpackage

// File: design/heater_pid_burst_power_modulator_top.sv
// Heater burst-fire power modulator with PID control: top level.
// Each transfer on the input channel is one command (tick, set power, shift power,
// pid update, start, stop) and yields exactly one result transfer carrying the heater
// drive level, the power level and the run flag after that command. An item goes
// from an input register through combinational logic into the state and the result
// register, so the block takes one item per clock cycle unless the result channel
// stalls; the critical path is the pid stage with its three multipliers (16-bit
// gains by 17-bit and 18-bit errors) and the clamps behind them. Configuration writes
// take effect at once; the user must make them while no item is in flight, the block does not enforce it.
module heater_pid_burst_power_modulator_top (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    // relay_on[0], power_request[8:1], power_step[16:9], measured_temp[32:17],
    // target_temp[48:33], zero fill[55:49]
    input  logic [55:0] s_tdata,
    // action[2:0]
    input  logic [2:0]  s_tuser,
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    // heater_drive[0], power_level[8:1], running[9], zero fill[15:10]
    output logic [15:0] m_tdata,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    import hpbm_pkg::*;

    // configuration registers
    logic [7:0]  full_scale_reg;
    logic        relay_present_reg;
    logic [15:0] gain_p_reg;
    logic [15:0] gain_i_reg;
    logic [15:0] gain_d_reg;

    // input stage
    logic        in_valid_reg;
    in_item_t    in_item_reg;

    // modulator and pid state
    logic [9:0]          acc_reg, acc_next;
    logic                phase_reg, phase_next;
    logic [7:0]          power_reg, power_next;
    logic                drive_reg, drive_next;
    logic                run_reg, run_next;
    logic [INTEG_W-1:0]  integ_reg, integ_next;
    logic signed [16:0]  prev_err_reg, prev_err_next;

    // result stage
    logic        out_valid_reg;
    logic        out_drive_reg;
    logic [7:0]  out_power_reg;
    logic        out_run_reg;

    logic        advance;
    pid_result_t pid_res;
    logic signed [11:0] tick_diff;
    logic [11:0] tick_wrap;
    logic [9:0]  shift_sum;
    logic [7:0]  level_req;

    // handshake: the item moves on when the result register is free or drains
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_scale_reg    <= FULL_SCALE_RESET;
            relay_present_reg <= 1'b0;
            gain_p_reg        <= '0;
            gain_i_reg        <= '0;
            gain_d_reg        <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_FULL_SCALE: full_scale_reg    <= cfg_wdata[7:0];
                CFG_RELAY:      relay_present_reg <= cfg_wdata[0];
                CFG_GAIN_P:     gain_p_reg        <= cfg_wdata;
                CFG_GAIN_I:     gain_i_reg        <= cfg_wdata;
                CFG_GAIN_D:     gain_d_reg        <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.action        <= action_t'(s_tuser);
            in_item_reg.relay_on      <= s_tdata[0];
            in_item_reg.power_request <= s_tdata[8:1];
            in_item_reg.power_step    <= $signed(s_tdata[16:9]);
            in_item_reg.measured_temp <= $signed(s_tdata[32:17]);
            in_item_reg.target_temp   <= $signed(s_tdata[48:33]);
        end
    end

    hpbm_pid u_pid (
        .measured_temp (in_item_reg.measured_temp),
        .target_temp   (in_item_reg.target_temp),
        .integ_in      (integ_reg),
        .prev_err      (prev_err_reg),
        .gain_p        (gain_p_reg),
        .gain_i        (gain_i_reg),
        .gain_d        (gain_d_reg),
        .result        (pid_res)
    );

    // burst-fire accumulator step, wraps by full scale on underflow
    assign tick_diff = {{2{acc_reg[9]}}, acc_reg} - {4'b0, power_reg};
    assign tick_wrap = tick_diff + {4'b0, full_scale_reg};

    // shifted level, kept only if it stays in 0..full scale
    assign shift_sum = {2'b00, power_reg} + {{2{in_item_reg.power_step[7]}},
                                             in_item_reg.power_step};

    // requested level for set power, from the command or from the pid stage
    assign level_req = (in_item_reg.action == ACT_PID) ? {1'b0, pid_res.level}
                                                      : in_item_reg.power_request;

    // next state for the item in the input register
    always_comb begin
        acc_next      = acc_reg;
        phase_next    = phase_reg;
        power_next    = power_reg;
        drive_next    = drive_reg;
        run_next      = run_reg;
        integ_next    = integ_reg;
        prev_err_next = prev_err_reg;
        unique case (in_item_reg.action)
            ACT_TICK: begin
                if (!run_reg) begin
                    drive_next = 1'b0;
                end else if (!relay_present_reg || in_item_reg.relay_on) begin
                    phase_next = !phase_reg;
                    // fire decision on every second tick that passes the relay gate
                    if (!phase_reg) begin
                        if (tick_diff[11]) begin
                            acc_next   = tick_wrap[9:0];
                            drive_next = 1'b1;
                        end else begin
                            acc_next   = tick_diff[9:0];
                            drive_next = 1'b0;
                        end
                    end
                end
            end
            ACT_SET, ACT_PID: begin
                if (in_item_reg.action == ACT_PID) begin
                    integ_next    = pid_res.integ;
                    prev_err_next = pid_res.err;
                end
                // compared before clamping; any change recentres the accumulator
                if (level_req != power_reg) begin
                    power_next = (level_req > full_scale_reg) ? full_scale_reg : level_req;
                    acc_next   = {3'b000, full_scale_reg[7:1]};
                end
            end
            ACT_SHIFT: begin
                if (!shift_sum[9] && (shift_sum[8:0] <= {1'b0, full_scale_reg})) begin
                    power_next = shift_sum[7:0];
                end
            end
            ACT_START: run_next = 1'b1;
            ACT_STOP:  run_next = 1'b0;
            default: ;
        endcase
    end

    // state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg      <= '0;
            phase_reg    <= 1'b0;
            power_reg    <= '0;
            drive_reg    <= 1'b0;
            run_reg      <= 1'b0;
            integ_reg    <= '0;
            prev_err_reg <= '0;
        end else if (advance) begin
            acc_reg      <= acc_next;
            phase_reg    <= phase_next;
            power_reg    <= power_next;
            drive_reg    <= drive_next;
            run_reg      <= run_next;
            integ_reg    <= integ_next;
            prev_err_reg <= prev_err_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_drive_reg <= drive_next;
            out_power_reg <= power_next;
            out_run_reg   <= run_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_run_reg, out_power_reg, out_drive_reg};

endmodule

// File: design/hpbm_pid.sv
// fixed-point pid step: error, clamped integral and clamped output level
module hpbm_pid (
    input  logic signed [15:0]              measured_temp,
    input  logic signed [15:0]              target_temp,
    input  logic [hpbm_pkg::INTEG_W-1:0]    integ_in,
    input  logic signed [16:0]              prev_err,
    input  logic [15:0]                     gain_p,
    input  logic [15:0]                     gain_i,
    input  logic [15:0]                     gain_d,
    output hpbm_pkg::pid_result_t           result
);
    import hpbm_pkg::*;

    logic signed [16:0] err;
    logic signed [17:0] derr;
    logic signed [33:0] p_prod;
    logic signed [33:0] i_prod;
    logic signed [34:0] d_prod;
    logic signed [35:0] integ_sum;
    logic [INTEG_W-1:0] integ_clamped;
    logic signed [36:0] out_sum;
    logic [INTEG_W-1:0] out_clamped;

    // error and its change since the last update
    assign err  = 17'(target_temp) - 17'(measured_temp);
    assign derr = 18'(err) - 18'(prev_err);

    // gain products, Q8.8 times the Q13.4 error (Q14.4 for its change)
    assign p_prod = $signed({1'b0, gain_p}) * err;
    assign i_prod = $signed({1'b0, gain_i}) * err;
    assign d_prod = $signed({1'b0, gain_d}) * derr;

    // integral accumulate and clamp to 0..100
    assign integ_sum = 36'(i_prod) + 36'($signed({1'b0, integ_in}));

    always_comb begin
        if (integ_sum[35]) begin
            integ_clamped = '0;
        end else if (integ_sum[34:0] > 35'(INTEG_TOP)) begin
            integ_clamped = INTEG_TOP;
        end else begin
            integ_clamped = integ_sum[INTEG_W-1:0];
        end
    end

    // output sum and clamp to 0..100
    assign out_sum = 37'(p_prod) + 37'(d_prod) + 37'($signed({1'b0, integ_clamped}));

    always_comb begin
        if (out_sum[36]) begin
            out_clamped = '0;
        end else if (out_sum[35:0] > 36'(INTEG_TOP)) begin
            out_clamped = INTEG_TOP;
        end else begin
            out_clamped = out_sum[INTEG_W-1:0];
        end
    end

    // truncate the fraction for the new level
    assign result.integ = integ_clamped;
    assign result.err   = err;
    assign result.level = out_clamped[INTEG_W-1:Q_FRAC];

endmodule

// File: verif/heater_pid_burst_power_modulator_top_tb.sv
// testbench of the heater burst-fire power modulator: status prediction and checking
module heater_pid_burst_power_modulator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hpbm_pkg::*;

    // unused action codes, which must leave the state alone
    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;

    localparam longint PID_CEIL   = 100;
    localparam int     PID_FRAC   = 12;
    localparam int     CYCLE_CAP  = 500000;
    localparam int     PHASES     = 8;
    localparam int     PHASE_ITEMS = 190;

    // heater status carried by one result transfer
    typedef struct packed {
        logic       drive;
        logic [7:0] level;
        logic       running;
    } status_t;

    // tracks the modulator state and holds the status words still to come
    class heater_tracker;
        logic [7:0]  full_scale;
        logic        relay_gate;
        logic [15:0] kp, ki, kd;
        logic [9:0]  acc;
        logic        phase;
        logic [7:0]  level;
        logic        drive;
        logic        run;
        longint      integ;
        logic [16:0] last_err;
        status_t     status_queue[$];
        int          errors;

        function new();
            full_scale = FULL_SCALE_RESET;
            relay_gate = 1'b0;
            kp = '0;
            ki = '0;
            kd = '0;
            acc = '0;
            phase = 1'b0;
            level = '0;
            drive = 1'b0;
            run = 1'b0;
            integ = 0;
            last_err = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] val);
            case (idx)
                CFG_FULL_SCALE: full_scale = val[7:0];
                CFG_RELAY:      relay_gate = val[0];
                CFG_GAIN_P:     kp = val;
                CFG_GAIN_I:     ki = val;
                CFG_GAIN_D:     kd = val;
                default: ;
            endcase
        endfunction

        // new level: compared before clamping, recenters the accumulator on change
        function void set_level(longint req);
            if (req == longint'(level))
                return;
            level = (req > longint'(full_scale)) ? full_scale : req[7:0];
            acc = 10'(full_scale >> 1);
        endfunction

        function void note_command(logic [2:0] act, logic [55:0] data);
            logic               relay;
            logic [7:0]         req;
            logic signed [7:0]  step;
            logic signed [15:0] meas, targ;
            longint             t, err, derr, outv;
            status_t            st;
            relay = data[0];
            req   = data[8:1];
            step  = data[16:9];
            meas  = data[32:17];
            targ  = data[48:33];
            case (act)
                ACT_TICK: begin
                    if (!run) begin
                        drive = 1'b0;
                    end else if (!(relay_gate && !relay)) begin
                        phase = ~phase;
                        if (phase) begin
                            t = longint'($signed(acc)) - longint'(level);
                            if (t < 0) begin
                                t += longint'(full_scale);
                                drive = 1'b1;
                            end else begin
                                drive = 1'b0;
                            end
                            acc = t[9:0];
                        end
                    end
                end
                ACT_SET: set_level(longint'(req));
                ACT_SHIFT: begin
                    t = longint'(level) + longint'(step);
                    if (t >= 0 && t <= longint'(full_scale))
                        level = t[7:0];
                end
                ACT_PID: begin
                    err = longint'(targ) - longint'(meas);
                    derr = err - longint'($signed(last_err));
                    integ = integ + longint'(ki) * err;
                    if (integ < 0) integ = 0;
                    if (integ > (PID_CEIL << PID_FRAC)) integ = PID_CEIL << PID_FRAC;
                    outv = longint'(kp) * err + integ + longint'(kd) * derr;
                    if (outv < 0) outv = 0;
                    if (outv > (PID_CEIL << PID_FRAC)) outv = PID_CEIL << PID_FRAC;
                    last_err = err[16:0];
                    set_level(outv >>> PID_FRAC);
                end
                ACT_START: run = 1'b1;
                ACT_STOP:  run = 1'b0;
                default: ;
            endcase
            st.drive = drive;
            st.level = level;
            st.running = run;
            status_queue.push_back(st);
        endfunction

        function void check_status(logic [15:0] data);
            status_t want;
            if (status_queue.size() == 0) begin
                $error("result transfer with no command pending, tdata %h", data);
                errors++;
                return;
            end
            want = status_queue.pop_front();
            if (data[0] !== want.drive) begin
                $error("heater_drive: expected %0d, actual %0d", want.drive, data[0]);
                errors++;
            end
            if (data[8:1] !== want.level) begin
                $error("power_level: expected %0d, actual %0d", want.level, data[8:1]);
                errors++;
            end
            if (data[9] !== want.running) begin
                $error("running: expected %0d, actual %0d", want.running, data[9]);
                errors++;
            end
        endfunction

        function int pending();
            return status_queue.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;

    heater_tracker tracker;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int cycles = 0;

    heater_pid_burst_power_modulator_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // result side back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // observe both channels; a command is noted before any status is checked
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                tracker.note_command(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                tracker.check_status(m_tdata);
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // one command transfer, with a random idle gap in front
    task automatic send_command(logic [2:0] act, logic relay, logic [7:0] req,
                                logic [7:0] step, logic [15:0] meas, logic [15:0] targ);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct && gap < 60)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {7'd0, targ, meas, step, req, relay};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // stop sending and let every pending status arrive
    task automatic wait_all_status();
        s_tvalid <= 1'b0;
        // wait for a clock edge so the last command transfer is surely noted
        @(posedge aclk);
        while (tracker.pending() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        tracker.write_reg(idx, val);
        @(posedge aclk);
    endtask

    // write every register while the block is idle
    task automatic configure(logic [7:0] fs, logic relay, logic [15:0] p,
                             logic [15:0] i, logic [15:0] d);
        wait_all_status();
        write_reg(CFG_FULL_SCALE, {8'd0, fs});
        write_reg(CFG_RELAY, {15'd0, relay});
        write_reg(CFG_GAIN_P, p);
        write_reg(CFG_GAIN_I, i);
        write_reg(CFG_GAIN_D, d);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_idling(int mode);
        case (mode)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 83; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 83; end
            default: begin tx_idle_pct = 8; rx_stall_pct = 8; end
        endcase
    endtask

    // weighted random command; fields not used by the action carry noise
    task automatic random_command();
        int          pick;
        logic [2:0]  act;
        logic        relay;
        logic [7:0]  req, step;
        logic [15:0] meas, targ;
        pick  = $urandom_range(99);
        relay = 1'($urandom_range(1));
        req   = 8'($urandom);
        step  = 8'($urandom);
        meas  = 16'($urandom);
        targ  = 16'($urandom);
        if (pick < 45) begin
            act = ACT_TICK;
            relay = ($urandom_range(9) != 0);
        end else if (pick < 56) begin
            act = ACT_SET;
            case ($urandom_range(3))
                0: req = tracker.level;
                1: req = 8'($urandom_range(tracker.full_scale));
                2: req = 8'($urandom_range(int'(PID_CEIL)));
                default: ;
            endcase
        end else if (pick < 66) begin
            act = ACT_SHIFT;
            if ($urandom_range(1))
                step = 8'($urandom_range(16)) - 8'd8;
        end else if (pick < 81) begin
            act = ACT_PID;
            if ($urandom_range(3) != 0)
                meas = targ + 16'($urandom_range(256)) - 16'd128;
        end else if (pick < 89) begin
            act = ACT_START;
        end else if (pick < 94) begin
            act = ACT_STOP;
        end else if (pick < 96) begin
            act = $urandom_range(1) ? ACT_SPARE_6 : ACT_SPARE_7;
        end else begin
            act = ACT_TICK;
        end
        send_command(act, relay, req, step, meas, targ);
    endtask

    initial begin
        tracker = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        set_idling(0);

        // directed: tick while stopped, set power equal and clamped, relay gating
        send_command(ACT_TICK, 1'b1, 8'd0, 8'd0, 16'd0, 16'd0);
        configure(8'd100, 1'b1, 16'h0100, 16'h0080, 16'h0040);
        send_command(ACT_SET, 1'b0, 8'd0, 8'd0, 16'd0, 16'd0);
        send_command(ACT_SET, 1'b0, 8'd255, 8'd0, 16'd0, 16'd0);
        send_command(ACT_SET, 1'b0, 8'd100, 8'd0, 16'd0, 16'd0);
        send_command(ACT_START, 1'b0, 8'd0, 8'd0, 16'd0, 16'd0);
        send_command(ACT_TICK, 1'b0, 8'd0, 8'd0, 16'd0, 16'd0);
        send_command(ACT_TICK, 1'b1, 8'd0, 8'd0, 16'd0, 16'd0);
        // stop with the heater on, then a tick clears the drive
        send_command(ACT_STOP, 1'b0, 8'd0, 8'd0, 16'd0, 16'd0);
        send_command(ACT_TICK, 1'b1, 8'd0, 8'd0, 16'd0, 16'd0);
        send_command(ACT_START, 1'b0, 8'd0, 8'd0, 16'd0, 16'd0);
        // shift power out of range both ways, then in range
        send_command(ACT_SHIFT, 1'b0, 8'd0, 8'sd127, 16'd0, 16'd0);
        send_command(ACT_SHIFT, 1'b0, 8'd0, 8'h80, 16'd0, 16'd0);
        send_command(ACT_SHIFT, 1'b0, 8'd0, 8'hCE, 16'd0, 16'd0);
        // pid at the temperature extremes and with no error
        send_command(ACT_PID, 1'b0, 8'd0, 8'd0, 16'h8000, 16'h7FFF);
        send_command(ACT_PID, 1'b0, 8'd0, 8'd0, 16'h7FFF, 16'h8000);
        send_command(ACT_PID, 1'b0, 8'd0, 8'd0, 16'h0190, 16'h0190);
        send_command(ACT_SPARE_6, 1'b1, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
        send_command(ACT_SPARE_7, 1'b1, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
        // widest full scale with saturating gains
        configure(8'd255, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_command(ACT_SET, 1'b0, 8'd255, 8'd0, 16'd0, 16'd0);
        send_command(ACT_TICK, 1'b0, 8'd0, 8'd0, 16'd0, 16'd0);
        send_command(ACT_TICK, 1'b0, 8'd0, 8'd0, 16'd0, 16'd0);
        send_command(ACT_PID, 1'b0, 8'd0, 8'd0, 16'd0, 16'd0);
        // full scale lowered to one, then full scale of zero
        configure(8'd1, 1'b0, 16'd0, 16'd0, 16'd0);
        send_command(ACT_TICK, 1'b0, 8'd0, 8'd0, 16'd0, 16'd0);
        send_command(ACT_TICK, 1'b0, 8'd0, 8'd0, 16'd0, 16'd0);
        configure(8'd0, 1'b0, 16'd0, 16'd0, 16'd0);
        send_command(ACT_SET, 1'b0, 8'd50, 8'd0, 16'd0, 16'd0);
        send_command(ACT_TICK, 1'b0, 8'd0, 8'd0, 16'd0, 16'd0);
        send_command(ACT_TICK, 1'b0, 8'd0, 8'd0, 16'd0, 16'd0);

        // random phases, each with a setting and one of four idling modes
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: configure(8'd100, 1'b0, 16'h0100, 16'h0010, 16'h0040);
                1: configure(8'd255, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                2: configure(8'd1, 1'b0, 16'd0, 16'd0, 16'd0);
                4: configure(8'd200, 1'b1, 16'($urandom_range(1023)),
                             16'($urandom_range(1023)), 16'($urandom_range(1023)));
                5: configure(8'd255, 1'b0, 16'($urandom_range(511)),
                             16'($urandom_range(63)), 16'($urandom_range(511)));
                7: configure(8'd100, 1'b1, 16'h0100, 16'h0004, 16'h0200);
                default: configure(8'($urandom_range(255, 1)), 1'($urandom_range(1)),
                                   16'($urandom), 16'($urandom), 16'($urandom));
            endcase
            set_idling(p % 4);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // hold off mid phase until every status is back
                if (n == PHASE_ITEMS / 2)
                    wait_all_status();
                random_command();
            end
        end

        wait_all_status();
        repeat (10) @(posedge aclk);
        if (tracker.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: files.f
design/hpbm_pkg.sv
design/hpbm_pid.sv
design/heater_pid_burst_power_modulator_top.sv
verif/heater_pid_burst_power_modulator_top_tb.sv
